@@ hw/rtl/mtbe_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI track byte encoder package
// Field widths, request codes and the fixed byte patterns of the stream.
// ----------------------------------------------------------------------------
package mtbe_pkg;

  localparam int REQ_W         = 2;
  localparam int EVENT_TIME_W  = 64;
  localparam int NOTE_W        = 7;
  localparam int VELOCITY_W    = 7;
  localparam int SLOWDOWN_W    = 32;
  localparam int LENGTH_W      = 32;
  localparam int BYTE_W        = 8;
  localparam int GROUP_W       = 7;
  localparam int MAX_DELTA_BYTES = 10;
  localparam int DELTA_W       = MAX_DELTA_BYTES * GROUP_W;
  localparam int TICKS_W       = 16;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [REQ_W-1:0] REQ_HEADER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOWDOWN = 1'd1;

  localparam logic [3:0] HDR_LAST_IDX = 4'd13;
  localparam logic [3:0] END_LAST_IDX = 4'd3;
  localparam logic [3:0] STAT_LAST_IDX = 4'd2;

  localparam logic [LENGTH_W-1:0] END_EVENT_BYTES = 32'd4;

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [3:0] idx,
                                                 input logic [TICKS_W-1:0] ticks);
    logic [BYTE_W-1:0] b;
    b = 8'h00;
    unique case (idx)
      4'd0:    b = 8'h4D;
      4'd1:    b = 8'h54;
      4'd2:    b = 8'h68;
      4'd3:    b = 8'h64;
      4'd7:    b = 8'h06;
      4'd11:   b = 8'h01;
      4'd12:   b = ticks[15:8];
      4'd13:   b = ticks[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] end_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    b = 8'h00;
    unique case (idx)
      4'd1:    b = 8'hFF;
      4'd2:    b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/mtbe_in_if.sv @@
// ----------------------------------------------------------------------------
// MIDI track byte encoder request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface mtbe_in_if import mtbe_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [EVENT_TIME_W-1:0] event_time;
  logic [NOTE_W-1:0]       note_number;
  logic                    note_on;

  modport source (output valid, output req_type, output event_time,
                  output note_number, output note_on, input ready);
  modport sink   (input valid, input req_type, input event_time,
                  input note_number, input note_on, output ready);
endinterface

@@ hw/rtl/mtbe_out_if.sv @@
// ----------------------------------------------------------------------------
// MIDI track byte encoder byte channel
// Valid/ready channel carrying one stream byte per beat.
// ----------------------------------------------------------------------------
interface mtbe_out_if import mtbe_pkg::*;;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_byte;
  logic [LENGTH_W-1:0] chunk_len;

  modport source (output valid, output out_byte, output last_byte,
                  output chunk_len, input ready);
  modport sink   (input valid, input out_byte, input last_byte,
                  input chunk_len, output ready);
endinterface

@@ hw/rtl/midi_track_byte_encoder.sv @@
// ----------------------------------------------------------------------------
// MIDI track byte encoder
// Turns header, note, end and clear requests into format-0 MIDI file bytes.
//
//   channel   direction  beat
//   in_ch     sink       one request: type, time stamp, note, note on
//   out_ch    source     one stream byte, last flag, track length
//   cfg_*     write      velocity (index 0), slowdown factor (index 1)
//
// One request is taken at a time; bytes leave at one per cycle when the sink
// is ready. A header runs the Q-bit divider, Q = clog2(TICK_RATE_HZ+1), then
// 14 bytes. A note runs a byte-serial subtraction over the 8 time stamp
// bytes and a search for the leading delta group, then its delta groups and
// 3 bytes. An end request takes 4 bytes; a clear emits none. Reset is
// synchronous; it resets the running state and the config registers.
// ----------------------------------------------------------------------------
module midi_track_byte_encoder import mtbe_pkg::*; #(
  parameter int TICK_RATE_HZ = 250
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mtbe_in_if.sink                in_ch,
  mtbe_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SLOWDOWN_W-1:0]  cfg_wdata
);

  localparam int QW = $clog2(TICK_RATE_HZ + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_NORM = 3'd4;
  localparam logic [2:0] S_DLT  = 3'd5;
  localparam logic [2:0] S_STAT = 3'd6;
  localparam logic [2:0] S_END  = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [3:0]              idx_r, idx_nxt;
  logic [3:0]              grp_r, grp_nxt;
  logic [EVENT_TIME_W-1:0] t_r, t_nxt;
  logic [EVENT_TIME_W-1:0] prev_r, prev_nxt;
  logic [DELTA_W-1:0]      delta_r, delta_nxt;
  logic                    borrow_r, borrow_nxt;
  logic                    seen_r, seen_nxt;
  logic [LENGTH_W-1:0]     body_r, body_nxt;
  logic [NOTE_W-1:0]       note_r, note_nxt;
  logic                    on_r, on_nxt;
  logic [VELOCITY_W-1:0]   vel_r;
  logic [SLOWDOWN_W-1:0]   slow_r;

  logic                    ov_r;
  logic [BYTE_W-1:0]       ob_r;
  logic                    ol_r;
  logic [LENGTH_W-1:0]     otl_r;

  logic                    accept;
  logic                    emit_ok;
  logic                    emit;
  logic [BYTE_W-1:0]       e_byte;
  logic                    e_last;
  logic [LENGTH_W-1:0]     e_len;
  logic                    div_start;
  logic                    div_done;
  logic [QW-1:0]           quotient;
  logic [TICKS_W-1:0]      ticks;
  logic [BYTE_W:0]         sub_res;
  logic [GROUP_W-1:0]      top_grp;

  mtbe_serdiv #(
    .DIVIDEND (TICK_RATE_HZ),
    .QW       (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (slow_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign ticks     = TICKS_W'(quotient);
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept    = in_ch.valid && (state_r == S_IDLE);
  assign div_start = accept && (in_ch.req_type == REQ_HEADER);
  assign emit_ok   = !ov_r || out_ch.ready;
  assign sub_res   = {1'b0, t_r[7:0]} - {1'b0, prev_r[7:0]} - {8'd0, borrow_r};
  assign top_grp   = delta_r[DELTA_W-1 -: GROUP_W];

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    grp_nxt    = grp_r;
    t_nxt      = t_r;
    prev_nxt   = prev_r;
    delta_nxt  = delta_r;
    borrow_nxt = borrow_r;
    seen_nxt   = seen_r;
    body_nxt   = body_r;
    note_nxt   = note_r;
    on_nxt     = on_r;
    emit       = 1'b0;
    e_byte     = '0;
    e_last     = 1'b0;
    e_len      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          borrow_nxt = 1'b0;
          t_nxt      = in_ch.event_time;
          note_nxt   = in_ch.note_number;
          on_nxt     = in_ch.note_on;
          unique case (in_ch.req_type)
            REQ_HEADER: state_nxt = S_DIV;
            REQ_NOTE:   state_nxt = S_SUB;
            REQ_END:    state_nxt = S_END;
            default: begin
              prev_nxt = '0;
              seen_nxt = 1'b0;
              body_nxt = '0;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        emit   = emit_ok;
        e_byte = hdr_byte(idx_r, ticks);
        e_last = (idx_r == HDR_LAST_IDX);
        if (emit) begin
          idx_nxt = idx_r + 4'd1;
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUB: begin
        t_nxt      = t_r >> BYTE_W;
        prev_nxt   = {t_r[7:0], prev_r[EVENT_TIME_W-1:BYTE_W]};
        borrow_nxt = sub_res[BYTE_W];
        delta_nxt  = {{(DELTA_W-EVENT_TIME_W){1'b0}},
                      seen_r ? sub_res[BYTE_W-1:0] : 8'h00,
                      delta_r[EVENT_TIME_W-1:BYTE_W]};
        idx_nxt    = idx_r + 4'd1;
        if (idx_r == 4'd7) begin
          seen_nxt  = 1'b1;
          grp_nxt   = 4'(MAX_DELTA_BYTES);
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if ((grp_r != 4'd1) && (top_grp == '0)) begin
          delta_nxt = delta_r << GROUP_W;
          grp_nxt   = grp_r - 4'd1;
        end else begin
          state_nxt = S_DLT;
        end
      end
      S_DLT: begin
        emit   = emit_ok;
        e_byte = {grp_r != 4'd1, top_grp};
        if (emit) begin
          body_nxt  = body_r + LENGTH_W'(1);
          delta_nxt = delta_r << GROUP_W;
          grp_nxt   = grp_r - 4'd1;
          if (grp_r == 4'd1) begin
            idx_nxt   = '0;
            state_nxt = S_STAT;
          end
        end
      end
      S_STAT: begin
        emit = emit_ok;
        case (idx_r)
          4'd0:    e_byte = {3'b100, on_r, 4'b0000};
          4'd1:    e_byte = {1'b0, note_r};
          default: e_byte = {1'b0, vel_r};
        endcase
        e_last = (idx_r == STAT_LAST_IDX);
        if (emit) begin
          body_nxt = body_r + LENGTH_W'(1);
          idx_nxt  = idx_r + 4'd1;
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_END: begin
        emit   = emit_ok;
        e_byte = end_byte(idx_r);
        e_last = (idx_r == END_LAST_IDX);
        e_len  = e_last ? body_r + END_EVENT_BYTES : '0;
        if (emit) begin
          idx_nxt = idx_r + 4'd1;
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= 1'b0;
      body_r  <= '0;
      prev_r  <= '0;
      ov_r    <= 1'b0;
      vel_r   <= 7'd63;
      slow_r  <= 32'd10;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      body_r  <= body_nxt;
      prev_r  <= prev_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VELOCITY: vel_r  <= cfg_wdata[VELOCITY_W-1:0];
          CFG_SLOWDOWN: slow_r <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    grp_r    <= grp_nxt;
    t_r      <= t_nxt;
    delta_r  <= delta_nxt;
    borrow_r <= borrow_nxt;
    note_r   <= note_nxt;
    on_r     <= on_nxt;
    if (emit) begin
      ob_r  <= e_byte;
      ol_r  <= e_last;
      otl_r <= e_len;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_byte  = ob_r;
  assign out_ch.last_byte = ol_r;
  assign out_ch.chunk_len = otl_r;

endmodule

@@ hw/rtl/mtbe_serdiv.sv @@
// ----------------------------------------------------------------------------
// MIDI track byte encoder serial divider
// Restoring division of a constant tick rate by the slowdown register, one
// quotient bit per cycle. A zero divisor is taken as one.
// ----------------------------------------------------------------------------
module mtbe_serdiv import mtbe_pkg::*; #(
  parameter int DIVIDEND = 250,
  parameter int QW       = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SLOWDOWN_W-1:0] divisor,
  output logic                  done,
  output logic [QW-1:0]         quotient
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] dvd_r;
  logic [QW-1:0] rem_r;
  logic [QW-1:0] quo_r;

  logic [SLOWDOWN_W-1:0] dsr;
  logic [QW:0]           trial;
  logic [QW:0]           diff;
  logic                  ge;

  assign dsr   = (divisor == '0) ? SLOWDOWN_W'(1) : divisor;
  assign trial = {rem_r, dvd_r[QW-1]};
  assign ge    = {{(SLOWDOWN_W-QW-1){1'b0}}, trial} >= dsr;
  assign diff  = trial - dsr[QW:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= QW'(DIVIDEND);
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[QW-1:0] : trial[QW-1:0];
      quo_r <= QW'({quo_r, ge});
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
